@@ design/mi3_pkg.sv @@
// shared constants, cofactor source table and status types for the 3x3 inverse
// no dependencies
`default_nettype none
package mi3_pkg;

  localparam int unsigned ELEM_WIDTH_C = 32;
  localparam int unsigned FRAC_BITS_C  = 16;
  localparam int unsigned N_ELEM       = 9;

  // cofactor k = a[p]*a[q] - a[r]*a[s], adjugate signs folded in
  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  typedef struct packed {
    logic neg;
    logic zero;
  } det_flags_t;

endpackage
`default_nettype wire

@@ design/mi3_cofactor.sv @@
// two stages: element products, then the nine adjugate cofactors
// depends on mi3_pkg
`default_nettype none
module mi3_cofactor import mi3_pkg::*; #(
  parameter int unsigned W = ELEM_WIDTH_C
) (
  input  wire  logic                clk_i,
  input  wire  logic                rst_ni,
  input  wire  logic                en_i,
  input  wire  logic                valid_i,
  input  wire  logic signed [W-1:0] a_i   [N_ELEM],
  output logic                      valid_o,
  output logic signed [2*W:0]       cof_o [N_ELEM],
  output logic signed [W-1:0]       col_o [3]
);

  logic signed [2*W-1:0] prod_d [N_ELEM][2];
  logic signed [2*W-1:0] prod_q [N_ELEM][2];
  logic signed [W-1:0]   col1_q [3];
  logic signed [2*W:0]   cof_d  [N_ELEM];
  logic signed [2*W:0]   cof_q  [N_ELEM];
  logic signed [W-1:0]   col2_q [3];
  logic                  v1_q, v2_q;

  for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
    assign prod_d[k][0] = a_i[COF_IDX[k][0]] * a_i[COF_IDX[k][1]];
    assign prod_d[k][1] = a_i[COF_IDX[k][2]] * a_i[COF_IDX[k][3]];
    always_comb begin
      cof_d[k] = (2*W+1)'(prod_q[k][0]) - (2*W+1)'(prod_q[k][1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      cof_q  <= cof_d;
      for (int j = 0; j < 3; j++) begin
        col1_q[j] <= a_i[3*j];
        col2_q[j] <= col1_q[j];
      end
    end
  end

  assign valid_o = v2_q;
  assign cof_o   = cof_q;
  assign col_o   = col2_q;

endmodule
`default_nettype wire

@@ design/mi3_det.sv @@
// three stages: split partial products, first column terms, determinant sum
// depends on mi3_pkg
`default_nettype none
module mi3_det import mi3_pkg::*; #(
  parameter int unsigned W = ELEM_WIDTH_C
) (
  input  wire  logic                clk_i,
  input  wire  logic                rst_ni,
  input  wire  logic                en_i,
  input  wire  logic                valid_i,
  input  wire  logic signed [2*W:0] cof_i [N_ELEM],
  input  wire  logic signed [W-1:0] col_i [3],
  output logic                      valid_o,
  output logic [3*W-1:0]            det_mag_o,
  output det_flags_t                det_flags_o,
  output logic [2*W-1:0]            cof_mag_o [N_ELEM],
  output logic                      cof_neg_o [N_ELEM]
);

  localparam int unsigned DW = 3*W + 2;

  logic signed [2*W:0]   plo_d [3], plo_q [3], phi_d [3], phi_q [3];
  logic signed [DW-1:0]  term_d [3], term_q [3];
  logic signed [DW-1:0]  det_d;
  logic signed [2*W:0]   c3_q [N_ELEM], c4_q [N_ELEM];
  logic [2*W-1:0]        cmag_d [N_ELEM], cmag_q [N_ELEM];
  logic                  cneg_q [N_ELEM];
  logic [3*W-1:0]        dmag_q;
  det_flags_t            dflg_q;
  logic                  v3_q, v4_q, v5_q;

  for (genvar j = 0; j < 3; j++) begin : g_term
    logic signed [W:0]    lo_s, hi_s;
    logic signed [DW-1:0] hi_x, lo_x;
    assign lo_s = $signed({1'b0, cof_i[j][W-1:0]});
    assign hi_s = $signed(cof_i[j][2*W:W]);
    assign plo_d[j] = col_i[j] * lo_s;
    assign phi_d[j] = col_i[j] * hi_s;
    assign hi_x = DW'(phi_q[j]);
    assign lo_x = DW'(plo_q[j]);
    assign term_d[j] = (hi_x <<< W) + lo_x;
  end

  assign det_d = term_q[0] + term_q[1] + term_q[2];

  for (genvar k = 0; k < N_ELEM; k++) begin : g_mag
    logic signed [2*W:0] c_neg;
    assign c_neg = -c4_q[k];
    assign cmag_d[k] = c4_q[k][2*W] ? c_neg[2*W-1:0] : c4_q[k][2*W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [DW-1:0] dn;
    if (en_i) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      c3_q   <= cof_i;
      term_q <= term_d;
      c4_q   <= c3_q;
      dn = -det_d;
      dmag_q      <= det_d[DW-1] ? dn[3*W-1:0] : det_d[3*W-1:0];
      dflg_q.neg  <= det_d[DW-1];
      dflg_q.zero <= (det_d == '0);
      cmag_q <= cmag_d;
      for (int k = 0; k < N_ELEM; k++) begin
        cneg_q[k] <= c4_q[k][2*W];
      end
    end
  end

  assign valid_o     = v5_q;
  assign det_mag_o   = dmag_q;
  assign det_flags_o = dflg_q;
  assign cof_mag_o   = cmag_q;
  assign cof_neg_o   = cneg_q;

endmodule
`default_nettype wire

@@ design/mi3_div.sv @@
// nine restoring divider lanes, one quotient bit per stage, then round and clamp
// depends on mi3_pkg
`default_nettype none
module mi3_div import mi3_pkg::*; #(
  parameter int unsigned W = ELEM_WIDTH_C,
  parameter int unsigned F = FRAC_BITS_C
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             en_i,
  input  wire  logic             valid_i,
  input  wire  logic [3*W-1:0]   det_mag_i,
  input  wire  det_flags_t       det_flags_i,
  input  wire  logic [2*W-1:0]   cof_mag_i [N_ELEM],
  input  wire  logic             cof_neg_i [N_ELEM],
  output logic                   valid_o,
  output logic [W-1:0]           r_o [N_ELEM],
  output logic                   singular_o,
  output logic                   saturated_o
);

  localparam int unsigned RA = 2*W + 2*F + 1;
  localparam int unsigned RB = 4*W + 2;
  localparam int unsigned RW = (RA > RB) ? RA : RB;
  localparam int unsigned NS = W + 2;
  localparam int unsigned QW = W + 3;
  localparam logic [QW-1:0] LIM_NEG = {3'b000, 1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

  logic [RW-1:0]  rem_q [NS+1][N_ELEM];
  logic [NS-1:0]  quo_q [NS+1][N_ELEM];
  logic           ovf_q [NS+1][N_ELEM];
  logic           neg_q [NS+1][N_ELEM];
  logic [RW-1:0]  dv_q  [NS+1];
  logic           sng_q [NS+1];
  logic           vld_q [NS+1];

  logic [W-1:0]   res_q [N_ELEM];
  logic           sat_d [N_ELEM];
  logic [W-1:0]   res_d [N_ELEM];
  logic           out_v_q, out_sng_q, out_sat_q;

  // entry stage: scale numerator, check for quotient overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [RW-1:0] num, dx;
    if (en_i) begin
      dx = RW'(det_mag_i);
      dv_q[0]  <= dx;
      sng_q[0] <= det_flags_i.zero;
      for (int k = 0; k < N_ELEM; k++) begin
        num = RW'(cof_mag_i[k]) << (2*F + 1);
        rem_q[0][k] <= num;
        quo_q[0][k] <= '0;
        ovf_q[0][k] <= (num >= (dx << NS));
        neg_q[0][k] <= cof_neg_i[k] ^ det_flags_i.neg;
      end
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    localparam int unsigned BI = NS - s;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      logic [RW-1:0] t;
      if (en_i) begin
        dv_q[s]  <= dv_q[s-1];
        sng_q[s] <= sng_q[s-1];
        t = dv_q[s-1] << BI;
        for (int k = 0; k < N_ELEM; k++) begin
          ovf_q[s][k] <= ovf_q[s-1][k];
          neg_q[s][k] <= neg_q[s-1][k];
          if (rem_q[s-1][k] >= t) begin
            rem_q[s][k] <= rem_q[s-1][k] - t;
            quo_q[s][k] <= quo_q[s-1][k] | (NS'(1) << BI);
          end else begin
            rem_q[s][k] <= rem_q[s-1][k];
            quo_q[s][k] <= quo_q[s-1][k];
          end
        end
      end
    end
  end

  for (genvar k = 0; k < N_ELEM; k++) begin : g_round
    logic [QW-1:0] qr, lim;
    logic [W-1:0]  mag;
    assign qr  = (QW'(quo_q[NS][k]) + QW'(1)) >> 1;
    assign lim = neg_q[NS][k] ? LIM_NEG : LIM_POS;
    assign sat_d[k] = ovf_q[NS][k] || (qr > lim);
    assign mag = sat_d[k] ? lim[W-1:0] : qr[W-1:0];
    assign res_d[k] = sng_q[NS] ? '0 : (neg_q[NS][k] ? -mag : mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    logic any;
    if (en_i) begin
      any = 1'b0;
      for (int k = 0; k < N_ELEM; k++) begin
        any = any | sat_d[k];
      end
      res_q     <= res_d;
      out_sng_q <= sng_q[NS];
      out_sat_q <= any & ~sng_q[NS];
    end
  end

  assign valid_o     = out_v_q;
  assign r_o         = res_q;
  assign singular_o  = out_sng_q;
  assign saturated_o = out_sat_q;

endmodule
`default_nettype wire

@@ design/matrix3x3_inverse.sv @@
// top level: 3x3 fixed-point matrix inverse by adjugate over determinant
// depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_div
//
// channel  dir  tdata                         tuser
// s_axis   in   a00..a22, W bits each         none
// m_axis   out  r00..r22, W bits each         singular, saturated
//
// one matrix per cycle while m_axis is not stalled; the pipeline has 2 cofactor stages,
// 3 determinant stages, 1 divider entry, ELEM_WIDTH+2 quotient bit stages, 1 output
// the quotient bit stages resolve one bit of all nine lanes per stage
// reset clears only the valid bits of every stage
// a stall on m_axis freezes the whole pipeline; the output register holds its beat
`default_nettype none
module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_C,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_C,
  localparam int unsigned DBITS = ((9*ELEM_WIDTH + 7) / 8) * 8
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire  logic [DBITS-1:0] s_axis_tdata_i,  // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic                   m_axis_tvalid_o,
  input  wire  logic             m_axis_tready_i,
  output logic [DBITS-1:0]       m_axis_tdata_o,  // r00,r01,r02,r10,r11,r12,r20,r21,r22
  output logic [1:0]             m_axis_tuser_o   // singular, saturated
);

  localparam int unsigned W = ELEM_WIDTH;

  logic                  en;
  logic signed [W-1:0]   a   [N_ELEM];
  logic                  cf_v;
  logic signed [2*W:0]   cof [N_ELEM];
  logic signed [W-1:0]   col [3];
  logic                  dt_v;
  logic [3*W-1:0]        dmag;
  det_flags_t            dflg;
  logic [2*W-1:0]        cmag [N_ELEM];
  logic                  cneg [N_ELEM];
  logic                  out_v, sng, sat;
  logic [W-1:0]          r   [N_ELEM];

  assign en = ~out_v | m_axis_tready_i;
  assign s_axis_tready_o = en;

  for (genvar k = 0; k < N_ELEM; k++) begin : g_io
    assign a[k] = $signed(s_axis_tdata_i[k*W +: W]);
    assign m_axis_tdata_o[k*W +: W] = r[k];
  end
  if (DBITS > 9*W) begin : g_pad
    assign m_axis_tdata_o[DBITS-1:9*W] = '0;
  end

  mi3_cofactor #(.W(W)) u_cof (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid_i), .a_i(a),
    .valid_o(cf_v), .cof_o(cof), .col_o(col)
  );

  mi3_det #(.W(W)) u_det (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cf_v), .cof_i(cof), .col_i(col),
    .valid_o(dt_v), .det_mag_o(dmag), .det_flags_o(dflg),
    .cof_mag_o(cmag), .cof_neg_o(cneg)
  );

  mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dt_v), .det_mag_i(dmag),
    .det_flags_i(dflg), .cof_mag_i(cmag), .cof_neg_i(cneg),
    .valid_o(out_v), .r_o(r), .singular_o(sng), .saturated_o(sat)
  );

  assign m_axis_tvalid_o = out_v;
  assign m_axis_tuser_o  = {sat, sng};

  a_sng_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tuser_o[1])
    else $error("singular beat flagged saturated");

  a_sng_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("singular beat with nonzero data");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

endmodule
`default_nettype wire

@@ dv/matrix3x3_inverse_test.sv @@
// testbench for the 3x3 fixed-point matrix inverse: streams matrices with random
// gaps and output stalls, predicts each inverse with exact wide arithmetic
// depends on mi3_pkg and matrix3x3_inverse
`default_nettype none
module matrix3x3_inverse_test;
  import mi3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = ELEM_WIDTH_C;
  localparam int F = FRAC_BITS_C;
  localparam int DB = ((9*W + 7) / 8) * 8;
  localparam int LATENCY = W + 9;
  localparam int WATCHDOG = 20000;

  typedef logic signed [W-1:0] elem_t;
  typedef elem_t mat_t [9];
  typedef struct {
    logic [DB-1:0] data;
    logic [1:0]    flags;
  } inverse_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [DB-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [DB-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;

  logic [DB-1:0] pending_mats [$];
  inverse_t expected_inverses [$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_send = 0;
  bit all_queued = 0;

  matrix3x3_inverse dut (.*);

  initial forever #1 clk_i = ~clk_i;

  function automatic inverse_t invert(input logic [DB-1:0] packed_mat);
    logic signed [W-1:0] a [9];
    logic signed [2*W+1:0] cof [9];
    logic signed [3*W+3:0] det;
    logic signed [5*W+3:0] num, q, rem, qmag;
    logic signed [5*W+3:0] dmag, maxp, minn;
    inverse_t res;
    bit sat;
    sat = 0;
    res.data = '0;
    for (int k = 0; k < 9; k++) a[k] = packed_mat[k*W +: W];
    for (int k = 0; k < 9; k++)
      cof[k] = a[COF_IDX[k][0]] * a[COF_IDX[k][1]] - a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
    det = a[0] * cof[0] + a[3] * cof[1] + a[6] * cof[2];
    if (det == 0) begin
      res.flags = 2'b01;
      return res;
    end
    dmag = det < 0 ? -det : det;
    maxp = (1 <<< (W-1)) - 1;
    minn = -(1 <<< (W-1));
    for (int k = 0; k < 9; k++) begin
      num = cof[k];
      num = num <<< (2*F);
      if (num < 0) num = -num;
      qmag = num / dmag;
      rem = num % dmag;
      if (2*rem >= dmag) qmag = qmag + 1;
      q = ((cof[k] < 0) != (det < 0)) ? -qmag : qmag;
      if (q > maxp) begin q = maxp; sat = 1; end
      if (q < minn) begin q = minn; sat = 1; end
      res.data[k*W +: W] = q[W-1:0];
    end
    res.flags = {sat, 1'b0};
    return res;
  endfunction

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // sender: bursts with gaps
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_inverses.push_back(invert(s_axis_tdata_i));
      void'(pending_mats.pop_front());
    end
    if (!rst_ni || hold_send) begin
      s_axis_tvalid_i <= 0;
    end else if (s_axis_tvalid_i && !s_axis_tready_o) begin
      s_axis_tvalid_i <= 1;
    end else begin
      logic [DB-1:0] nxt;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid_i <= 0;
      end else if (pending_mats.size() > 0) begin
        nxt = pending_mats[0];
        s_axis_tvalid_i <= 1;
        s_axis_tdata_i <= nxt;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid_i <= 0;
      end
    end
  end

  // receiver: stall pattern and checking
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 0;
    end else begin
      logic rdy;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_inverses.size() == 0) begin
          report("result with nothing expected");
        end else begin
          inverse_t e;
          e = expected_inverses.pop_front();
          for (int k = 0; k < 9; k++)
            if (m_axis_tdata_o[k*W +: W] !== e.data[k*W +: W])
              report($sformatf("r%0d%0d got %h want %h", k/3, k%3,
                m_axis_tdata_o[k*W +: W], e.data[k*W +: W]));
          if (m_axis_tuser_o[0] !== e.flags[0])
            report($sformatf("singular got %b want %b", m_axis_tuser_o[0], e.flags[0]));
          if (m_axis_tuser_o[1] !== e.flags[1])
            report($sformatf("saturated got %b want %b", m_axis_tuser_o[1], e.flags[1]));
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2: rdy = 0;
        default: rdy = 1;
      endcase
      if (($urandom >> 6) % 300 < 100) rdy = 1;
      m_axis_tready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic elem_t rand_elem(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      2: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      default: return ($urandom_range(0, 1) ? elem_t'(1 << F) : elem_t'(-(1 << F)))
        * $signed($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [DB-1:0] pack(input mat_t m);
    logic [DB-1:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*W +: W] = m[k];
    return d;
  endfunction

  task automatic add_mat(input mat_t m);
    pending_mats.push_back(pack(m));
  endtask

  initial begin
    mat_t m;
    elem_t mx, mn, one;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    one = 1 << F;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    // identity, scaled, singular, extremes, permutation, tridiagonal
    m = '{one, 0, 0, 0, one, 0, 0, 0, one}; add_mat(m);
    m = '{-one, 0, 0, 0, 2*one, 0, 0, 0, one/2}; add_mat(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; add_mat(m);
    m = '{one, 2*one, 3*one, 2*one, 4*one, 6*one, 1, 5, 7}; add_mat(m);
    m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx}; add_mat(m);
    m = '{mn, 0, 0, 0, mn, 0, 0, 0, mn}; add_mat(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; add_mat(m);
    m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1}; add_mat(m);
    m = '{mx, mn, mx, mn, mx, mn, mx, mx, mn}; add_mat(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; add_mat(m);
    m = '{mn, mx, 1, 3, mn, -1, mx, 7, mn}; add_mat(m);
    m = '{0, one, 0, 0, 0, one, one, 0, 0}; add_mat(m);
    m = '{3, 0, 0, 0, 3, 0, 0, 0, 3}; add_mat(m);
    m = '{2*one, one, 0, one, 2*one, one, 0, one, 2*one}; add_mat(m);
    wait (pending_mats.size() == 0);
    hold_send = 1;
    wait (expected_inverses.size() == 0);
    hold_send = 0;
    for (int i = 0; i < 600; i++) begin
      int mode;
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++) m[k] = rand_elem(mode);
      if ($urandom_range(0, 9) == 0) for (int k = 0; k < 3; k++) m[6+k] = m[k];
      add_mat(m);
    end
    all_queued = 1;
    wait (pending_mats.size() == 0 && !s_axis_tvalid_i);
    wait (expected_inverses.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
design/mi3_pkg.sv
design/mi3_cofactor.sv
design/mi3_det.sv
design/mi3_div.sv
design/matrix3x3_inverse.sv
dv/matrix3x3_inverse_test.sv
